// ===== design/bctm_pkg.sv =====
`default_nettype none
package bctm_pkg;

  // Pool geometry
  localparam int ENTRIES   = 32;
  localparam int DISK_SIZE = 8192;
  localparam int AGE_BITS  = 16;

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LEVELS  = IDX_W;
  localparam int NPAD    = 1 << LEVELS;
  localparam int LVL_W   = $clog2(LEVELS + 1);

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int BN_W      = 16;
  localparam int TAG_W     = 15;
  localparam int ST_W      = 2;
  localparam int OUT_IDX_W = 5;

  localparam logic [AGE_BITS-1:0] AGE_MAX    = {AGE_BITS{1'b1}};
  localparam logic [BN_W-1:0]     DISK_LIMIT = BN_W'(DISK_SIZE);

  // Request opcodes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
  localparam logic [OP_W-1:0] OP_DIRTY  = 2'd2;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd3;

  // Result status
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_OOB  = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  // Classified command kinds
  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DIRTY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OOB    = 3'd4;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [CMD_W-1:0] kind;
    logic [TAG_W-1:0] bn;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 wb_valid;
    logic [OUT_IDX_W-1:0] wb_index;
    logic [TAG_W-1:0]     wb_block;
    logic                 last;
  } res_t;

endpackage
`default_nettype wire

// ===== design/buffer_cache_tag_manager_core.sv =====
`default_nettype none
// Flow: a beat accepted into the queue is popped when the back end is idle, and its result
// is registered onto out_*; flush and allocate into a full pool pass through further states.
// Back end per request: lookup, set-dirty, out-of-bound, free-entry allocate finish in S_IDLE;
// full-pool allocate goes through S_IDLE, S_TREE and S_EVICT, with the victim search
// tree reduced one level per cycle in S_TREE; flush gives one result per dirty entry, or one if none.
// Reset (rst_n low, sync): entries free and clean, 2-deep queue empty; receiver cannot stall.
module buffer_cache_tag_manager_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bctm_pkg::OP_W-1:0]         in_opcode,
  input  wire logic signed [bctm_pkg::BN_W-1:0]  in_block_number,
  output logic                                   out_valid,
  output logic [bctm_pkg::ST_W-1:0]              out_status,
  output logic [bctm_pkg::OUT_IDX_W-1:0]         out_entry_index,
  output logic                                   out_writeback_valid,
  output logic [bctm_pkg::OUT_IDX_W-1:0]         out_writeback_index,
  output logic [bctm_pkg::TAG_W-1:0]             out_writeback_block,
  output logic                                   out_last
);
  import bctm_pkg::*;

  logic cmd_valid, pop;
  cmd_t cmd;
  res_t res;

  // Front: classify the request (opcode, bound check) and queue it.
  bctm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .opcode       (in_opcode),
    .block_number (in_block_number),
    .busy         (busy),
    .pop          (pop),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd)
  );

  // Back: entry metadata, tag match, aging, victim search, flush walk.
  // Each result shows on out_* for one cycle with out_valid.
  bctm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_status          = res.status;
  assign out_entry_index     = res.entry_index;
  assign out_writeback_valid = res.wb_valid;
  assign out_writeback_index = res.wb_index;
  assign out_writeback_block = res.wb_block;
  assign out_last            = res.last;

  // Failed requests carry no entry and no writeback.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_entry_index == '0 && !out_writeback_valid))
    else $error("failed request reports an entry or writeback");

  // Writeback fields are zero unless a writeback is requested.
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_writeback_valid) |->
      (out_writeback_index == '0 && out_writeback_block == '0))
    else $error("writeback fields set without writeback");

  // Only in-bound blocks ever get into the pool.
  a_wb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_writeback_valid) |-> ({1'b0, out_writeback_block} < DISK_LIMIT))
    else $error("writeback of an out-of-bound block");

  // Queue comes out of reset empty.
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> (!busy && !out_valid))
    else $error("queue or output not cleared by reset");

endmodule
`default_nettype wire

// ===== design/bctm_front.sv =====
`default_nettype none
module bctm_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [bctm_pkg::OP_W-1:0]  opcode,
  input  wire logic signed [bctm_pkg::BN_W-1:0] block_number,
  output logic                            busy,
  input  wire logic                       pop,
  output logic                            cmd_valid,
  output bctm_pkg::cmd_t                  cmd
);
  import bctm_pkg::*;

  cmd_t               q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push, do_pop, oob;
  cmd_t               cls;

  // classify: flush ignores the block number
  always_comb begin
    oob = block_number[BN_W-1] || ({1'b0, block_number[TAG_W-1:0]} >= DISK_LIMIT);
    cls.bn = block_number[TAG_W-1:0];
    if (opcode == OP_FLUSH) begin
      cls.kind = CMD_FLUSH;
    end else if (oob) begin
      cls.kind = CMD_OOB;
    end else begin
      case (opcode)
        OP_LOOKUP: cls.kind = CMD_LOOKUP;
        OP_ALLOC:  cls.kind = CMD_ALLOC;
        OP_DIRTY:  cls.kind = CMD_DIRTY;
        default:   cls.kind = CMD_FLUSH;
      endcase
    end
  end

  assign busy      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = start && !busy;
  assign do_pop    = pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : Q_PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : Q_PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !do_pop) begin
      cnt_nxt = Q_CNT_W'(cnt_r + 1'b1);
    end else if (!push && do_pop) begin
      cnt_nxt = Q_CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== design/bctm_back.sv =====
`default_nettype none
module bctm_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  input  wire bctm_pkg::cmd_t cmd,
  output logic                pop,
  output logic                res_valid,
  output bctm_pkg::res_t      res
);
  import bctm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FLUSH = 2'd1;
  localparam logic [1:0] S_TREE  = 2'd2;
  localparam logic [1:0] S_EVICT = 2'd3;

  // entry metadata
  logic [ENTRIES-1:0]  occ_r, dirty_r;
  logic [TAG_W-1:0]    tag_r [ENTRIES];
  logic [AGE_BITS-1:0] age_r [ENTRIES];

  // victim search tree, reduced in place one level per cycle
  logic [AGE_BITS-1:0] tree_age_r [NPAD];
  logic [IDX_W-1:0]    tree_idx_r [NPAD];

  logic [1:0]         state_r, state_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [ENTRIES-1:0] mask_r, mask_nxt, mask_rest;
  logic [TAG_W-1:0]   bn_r, bn_nxt;
  res_t               res_r, res_nxt;
  logic               res_valid_r, res_valid_nxt;

  logic [ENTRIES-1:0]  hit;
  logic [AGE_BITS-1:0] age_inc [ENTRIES];
  logic [IDX_W-1:0]    hit_idx, free_idx, flush_idx, vic_idx;
  logic                do_age, tree_load, tree_step, set_dirty, wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [TAG_W-1:0]    wr_bn;

  function automatic logic [IDX_W-1:0] first_idx(input logic [ENTRIES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  function automatic res_t mk_res(input logic [ST_W-1:0] st, input logic [IDX_W-1:0] idx,
                                  input logic wv, input logic [IDX_W-1:0] widx,
                                  input logic [TAG_W-1:0] wblk, input logic lst);
    res_t r;
    r.status      = st;
    r.entry_index = OUT_IDX_W'(idx);
    r.wb_valid    = wv;
    r.wb_index    = OUT_IDX_W'(widx);
    r.wb_block    = wblk;
    r.last        = lst;
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i]     = occ_r[i] && (tag_r[i] == cmd.bn);
      age_inc[i] = (occ_r[i] && (age_r[i] != AGE_MAX)) ? AGE_BITS'(age_r[i] + 1'b1) : age_r[i];
    end
  end

  assign hit_idx   = first_idx(hit);
  assign free_idx  = first_idx(~occ_r);
  assign flush_idx = first_idx(mask_r);
  assign mask_rest = mask_r & (mask_r - 1'b1);
  assign vic_idx   = tree_idx_r[0];

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    mask_nxt      = mask_r;
    bn_nxt        = bn_r;
    res_nxt       = res_r;
    res_valid_nxt = 1'b0;
    pop           = 1'b0;
    do_age        = 1'b0;
    tree_load     = 1'b0;
    tree_step     = 1'b0;
    set_dirty     = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = free_idx;
    wr_bn         = cmd.bn;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          case (cmd.kind)
            CMD_OOB: begin
              res_valid_nxt = 1'b1;
              res_nxt = mk_res(ST_OOB, '0, 1'b0, '0, '0, 1'b1);
            end
            CMD_LOOKUP, CMD_DIRTY: begin
              res_valid_nxt = 1'b1;
              if (hit != '0) begin
                set_dirty = (cmd.kind == CMD_DIRTY);
                res_nxt = mk_res(ST_OK, hit_idx, 1'b0, '0, '0, 1'b1);
              end else begin
                res_nxt = mk_res(ST_MISS, '0, 1'b0, '0, '0, 1'b1);
              end
            end
            CMD_FLUSH: begin
              mask_nxt  = occ_r & dirty_r;
              state_nxt = S_FLUSH;
            end
            CMD_ALLOC: begin
              do_age = 1'b1;
              bn_nxt = cmd.bn;
              if (occ_r != '1) begin
                wr_en         = 1'b1;
                res_valid_nxt = 1'b1;
                res_nxt = mk_res(ST_OK, free_idx, 1'b0, '0, '0, 1'b1);
              end else begin
                tree_load = 1'b1;
                lvl_nxt   = '0;
                state_nxt = S_TREE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FLUSH: begin
        res_valid_nxt = 1'b1;
        if (mask_r == '0) begin
          res_nxt   = mk_res(ST_OK, '0, 1'b0, '0, '0, 1'b1);
          state_nxt = S_IDLE;
        end else begin
          res_nxt  = mk_res(ST_OK, flush_idx, 1'b1, flush_idx, tag_r[flush_idx],
                            mask_rest == '0);
          mask_nxt = mask_rest;
          if (mask_rest == '0) state_nxt = S_IDLE;
        end
      end
      S_TREE: begin
        tree_step = 1'b1;
        lvl_nxt   = LVL_W'(lvl_r + 1'b1);
        if (lvl_r == LVL_W'(LEVELS - 1)) state_nxt = S_EVICT;
      end
      S_EVICT: begin
        wr_en         = 1'b1;
        wr_idx        = vic_idx;
        wr_bn         = bn_r;
        res_valid_nxt = 1'b1;
        if (dirty_r[vic_idx]) begin
          res_nxt = mk_res(ST_OK, vic_idx, 1'b1, vic_idx, tag_r[vic_idx], 1'b1);
        end else begin
          res_nxt = mk_res(ST_OK, vic_idx, 1'b0, '0, '0, 1'b1);
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      occ_r       <= '0;
      dirty_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      if (set_dirty) dirty_r[hit_idx] <= 1'b1;
      if (wr_en) begin
        occ_r[wr_idx]   <= 1'b1;
        dirty_r[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r  <= lvl_nxt;
    mask_r <= mask_nxt;
    bn_r   <= bn_nxt;
    res_r  <= res_nxt;
    if (do_age) begin
      for (int i = 0; i < ENTRIES; i++) age_r[i] <= age_inc[i];
    end
    if (wr_en) begin
      tag_r[wr_idx] <= wr_bn;
      age_r[wr_idx] <= '0;
    end
    if (tree_load) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tree_age_r[i] <= age_inc[i];
        tree_idx_r[i] <= IDX_W'(i);
      end
      for (int i = ENTRIES; i < NPAD; i++) begin
        tree_age_r[i] <= '0;
        tree_idx_r[i] <= '0;
      end
    end else if (tree_step) begin
      // right child wins only when strictly older
      for (int i = 0; i < NPAD / 2; i++) begin
        if (tree_age_r[2*i+1] > tree_age_r[2*i]) begin
          tree_age_r[i] <= tree_age_r[2*i+1];
          tree_idx_r[i] <= tree_idx_r[2*i+1];
        end else begin
          tree_age_r[i] <= tree_age_r[2*i];
          tree_idx_r[i] <= tree_idx_r[2*i];
        end
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire
